[hw/rtl/pne_pkg.sv]
// Shared types, constants and arithmetic helpers for the proof-number node evaluator.
package pne_pkg;

	localparam int unsigned MAX_CHILDREN_DEF = 1024;
	localparam int unsigned SUBTREE_BITS_DEF = 24;
	localparam int unsigned QUEUE_DEPTH      = 4;

	localparam logic [15:0] INF16           = 16'hffff;
	localparam logic [15:0] DEPTH_CAP_RESET = 16'd32;
	localparam logic [24:0] PRIO_START      = 25'h0ffff00;
	localparam logic [16:0] LN2_Q16         = 17'd45426;

	typedef struct packed {
		logic [15:0] node_depth;
		logic [15:0] child_proof;
		logic [15:0] child_disproof;
		logic [15:0] child_steps;
		logic [23:0] child_subtree;
		logic        child_present;
		logic        last_child;
	} item_t;

	typedef struct packed {
		logic [15:0] node_proof;
		logic [15:0] node_disproof;
		logic [15:0] node_steps;
		logic [23:0] node_subtree;
		logic        explore_found;
		logic [9:0]  explore_index;
		logic        mate_found;
		logic [9:0]  mate_index;
	} result_t;

	// One classified child word handed from the front to the back.
	typedef struct packed {
		logic        start;
		logic        is_or;
		logic        at_limit;
		logic        present;
		logic        last;
		logic        undecided;
		logic        proven;
		logic [15:0] proof;
		logic [15:0] disproof;
		logic [15:0] steps;
		logic [15:0] steps_inc;
		logic [23:0] subtree;
		logic [24:0] prio;
	} work_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? INF16 : s[15:0];
	endfunction

	function automatic logic [7:0] ln_frac_q8(input logic [3:0] m);
		logic [7:0] v;
		case (m)
			4'd0:    v = 8'd0;
			4'd1:    v = 8'd16;
			4'd2:    v = 8'd30;
			4'd3:    v = 8'd44;
			4'd4:    v = 8'd57;
			4'd5:    v = 8'd70;
			4'd6:    v = 8'd82;
			4'd7:    v = 8'd93;
			4'd8:    v = 8'd104;
			4'd9:    v = 8'd114;
			4'd10:   v = 8'd124;
			4'd11:   v = 8'd134;
			4'd12:   v = 8'd143;
			4'd13:   v = 8'd152;
			4'd14:   v = 8'd161;
			default: v = 8'd169;
		endcase
		return v;
	endfunction

	// Natural log in Q5.8 of a nonzero 24-bit size, from the leading one and four bits below it.
	function automatic logic [12:0] ln_q8(input logic [23:0] x);
		logic [4:0]  k;
		logic [27:0] xe;
		logic [27:0] sh;
		logic [20:0] prod;
		k = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (x[i]) begin
				k = 5'(i);
			end
		end
		xe = {x, 4'b0000};
		sh = xe >> k;
		prod = 21'(k) * 21'(LN2_Q16) + 21'd128;
		return prod[20:8] + 13'(ln_frac_q8(sh[3:0]));
	endfunction

endpackage

[hw/rtl/pne_queue.sv]
// Small register queue that decouples the classifier from the accumulator.
module pne_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = pne_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/pne_front.sv]
// Front end: accepts child words, tracks node boundaries and classifies each child.
module pne_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  pne_pkg::item_t  item,
	input  logic [15:0]     depth_cap,
	output logic            q_push,
	output pne_pkg::work_t  q_word
);

	logic        inside_q;
	logic        is_or_q;
	logic        at_limit_q;
	logic        cur_or;
	logic        cur_limit;
	logic        accept;
	logic [23:0] size_fix;
	logic [12:0] ln_size;

	assign accept = push && !full;
	assign q_push = accept;

	always_comb begin
		// The depth is only sampled on the first word of a node.
		cur_or    = inside_q ? is_or_q : !item.node_depth[0];
		cur_limit = inside_q ? at_limit_q : (item.node_depth >= depth_cap);
		size_fix  = (item.child_subtree == '0) ? 24'd1 : item.child_subtree;
		ln_size   = pne_pkg::ln_q8(size_fix);

		q_word.start     = !inside_q;
		q_word.is_or     = cur_or;
		q_word.at_limit  = cur_limit;
		q_word.present   = item.child_present;
		q_word.last      = item.last_child;
		q_word.undecided = (item.child_proof != '0) && (item.child_disproof != '0);
		q_word.proven    = (item.child_proof == '0);
		q_word.proof     = item.child_proof;
		q_word.disproof  = item.child_disproof;
		q_word.steps     = item.child_steps;
		q_word.steps_inc = pne_pkg::sat_add16(item.child_steps, 16'd1);
		q_word.subtree   = size_fix;
		q_word.prio      = 25'({(cur_or ? item.child_proof : item.child_disproof), 8'h00})
			+ 25'(ln_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			is_or_q    <= 1'b0;
			at_limit_q <= 1'b0;
		end else if (accept) begin
			inside_q   <= !item.last_child;
			is_or_q    <= cur_or;
			at_limit_q <= cur_limit;
		end
	end

endmodule

[hw/rtl/pne_back.sv]
// Back end: accumulates the node aggregate and selections, and holds the finished result.
module pne_back #(
	parameter int unsigned MAX_CHILDREN = pne_pkg::MAX_CHILDREN_DEF,
	parameter int unsigned SUBTREE_BITS = pne_pkg::SUBTREE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  pne_pkg::work_t   q_word,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output pne_pkg::result_t result
);

	localparam int unsigned CNT_W = $clog2(MAX_CHILDREN + 1);
	localparam int unsigned SUM_W = ((SUBTREE_BITS > 24) ? SUBTREE_BITS : 24) + 1;
	localparam logic [SUM_W-1:0] SUB_MAX = SUM_W'({SUBTREE_BITS{1'b1}});

	logic [15:0]             proof_q,    b_proof,    n_proof;
	logic [15:0]             disproof_q, b_disproof, n_disproof;
	logic [15:0]             steps_q,    b_steps,    n_steps;
	logic [SUBTREE_BITS-1:0] sub_q,      b_sub,      n_sub;
	logic [24:0]             prio_q,     b_prio,     n_prio;
	logic                    xfound_q,   b_xfound,   n_xfound;
	logic [CNT_W-1:0]        xidx_q,     b_xidx,     n_xidx;
	logic [15:0]             mstep_q,    b_mstep,    n_mstep;
	logic                    mfound_q,   b_mfound,   n_mfound;
	logic [CNT_W-1:0]        midx_q,     b_midx,     n_midx;
	logic [CNT_W-1:0]        cnt_q,      b_cnt,      n_cnt;
	logic [SUM_W-1:0]        sub_sum;
	logic                    selectable;
	logic                    mate_better;
	logic [CNT_W+9:0]        xidx_ext;
	logic [CNT_W+9:0]        midx_ext;
	logic [SUBTREE_BITS+23:0] sub_ext;
	logic                    out_valid_q;
	pne_pkg::result_t        res_d;
	pne_pkg::result_t        result_q;

	// A node's last word waits only when the held result is neither free nor leaving.
	assign q_pop  = q_valid && (!q_word.last || !out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = result_q;

	always_comb begin
		if (q_word.start) begin
			b_proof    = q_word.is_or ? pne_pkg::INF16 : 16'd0;
			b_disproof = q_word.is_or ? 16'd0 : pne_pkg::INF16;
			b_steps    = q_word.is_or ? pne_pkg::INF16 : 16'd1;
			b_sub      = SUBTREE_BITS'(1);
			b_prio     = pne_pkg::PRIO_START;
			b_xfound   = 1'b0;
			b_xidx     = '0;
			b_mstep    = q_word.is_or ? pne_pkg::INF16 : 16'd0;
			b_mfound   = 1'b0;
			b_midx     = '0;
			b_cnt      = '0;
		end else begin
			b_proof    = proof_q;
			b_disproof = disproof_q;
			b_steps    = steps_q;
			b_sub      = sub_q;
			b_prio     = prio_q;
			b_xfound   = xfound_q;
			b_xidx     = xidx_q;
			b_mstep    = mstep_q;
			b_mfound   = mfound_q;
			b_midx     = midx_q;
			b_cnt      = cnt_q;
		end

		n_proof    = b_proof;
		n_disproof = b_disproof;
		n_steps    = b_steps;
		n_sub      = b_sub;
		n_prio     = b_prio;
		n_xfound   = b_xfound;
		n_xidx     = b_xidx;
		n_mstep    = b_mstep;
		n_mfound   = b_mfound;
		n_midx     = b_midx;
		n_cnt      = b_cnt;

		selectable  = (b_cnt < CNT_W'(MAX_CHILDREN));
		sub_sum     = SUM_W'(b_sub) + SUM_W'(q_word.subtree);
		mate_better = q_word.is_or ? (q_word.steps < b_mstep) : (q_word.steps > b_mstep);

		if (q_word.present) begin
			if (q_word.is_or) begin
				n_proof    = (q_word.proof < b_proof) ? q_word.proof : b_proof;
				n_disproof = pne_pkg::sat_add16(b_disproof, q_word.disproof);
				n_steps    = (q_word.steps_inc < b_steps) ? q_word.steps_inc : b_steps;
			end else begin
				n_proof    = pne_pkg::sat_add16(b_proof, q_word.proof);
				n_disproof = (q_word.disproof < b_disproof) ? q_word.disproof : b_disproof;
				n_steps    = (q_word.steps_inc > b_steps) ? q_word.steps_inc : b_steps;
			end
			n_sub = (sub_sum > SUB_MAX) ? SUB_MAX[SUBTREE_BITS-1:0]
				: sub_sum[SUBTREE_BITS-1:0];

			// Children past the position limit still count in the aggregate.
			if (selectable) begin
				if (q_word.undecided && (q_word.prio < b_prio)) begin
					n_prio   = q_word.prio;
					n_xfound = 1'b1;
					n_xidx   = b_cnt;
				end
				if (q_word.proven && mate_better) begin
					n_mstep  = q_word.steps;
					n_mfound = 1'b1;
					n_midx   = b_cnt;
				end
				n_cnt = b_cnt + 1'b1;
			end
		end

		xidx_ext = {10'd0, n_xidx};
		midx_ext = {10'd0, n_midx};
		sub_ext  = {24'd0, n_sub};

		if (q_word.at_limit) begin
			res_d.node_proof    = pne_pkg::INF16;
			res_d.node_disproof = 16'd0;
			res_d.node_steps    = pne_pkg::INF16;
			res_d.node_subtree  = 24'd1;
		end else begin
			res_d.node_proof    = n_proof;
			res_d.node_disproof = n_disproof;
			res_d.node_steps    = n_steps;
			res_d.node_subtree  = sub_ext[23:0];
		end
		res_d.explore_found = n_xfound;
		res_d.explore_index = n_xfound ? xidx_ext[9:0] : 10'd0;
		res_d.mate_found    = n_mfound;
		res_d.mate_index    = n_mfound ? midx_ext[9:0] : 10'd0;
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_word.last) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			proof_q     <= '0;
			disproof_q  <= '0;
			steps_q     <= '0;
			sub_q       <= '0;
			prio_q      <= '0;
			xfound_q    <= 1'b0;
			xidx_q      <= '0;
			mstep_q     <= '0;
			mfound_q    <= 1'b0;
			midx_q      <= '0;
			cnt_q       <= '0;
		end else begin
			if (q_pop && q_word.last) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				proof_q    <= n_proof;
				disproof_q <= n_disproof;
				steps_q    <= n_steps;
				sub_q      <= n_sub;
				prio_q     <= n_prio;
				xfound_q   <= n_xfound;
				xidx_q     <= n_xidx;
				mstep_q    <= n_mstep;
				mfound_q   <= n_mfound;
				midx_q     <= n_midx;
				cnt_q      <= n_cnt;
			end
		end
	end

endmodule

[hw/rtl/proof_number_node_evaluator.sv]
// Top level of the proof-number node evaluator: config register, front, queue and back.
//
// Input side: a queue port. A child word is taken at a rising edge with push high and
// full low. The first word of a node carries its depth; even depth is an OR node, odd
// an AND node. A word with child_present low adds no child; last_child closes the node.
// Result side: a queue port. While empty is low the node result is on result, and it
// leaves at a rising edge with pop high. One result is produced per node.
// Throughput is one child word per cycle while full is low. Each word passes the
// classifier (size log in Q5.8 and priority) into a four-word queue; the accumulator
// retires one word a cycle unless a node's last word waits on the held result.
// The single result register holds while pop is low; the accumulator keeps absorbing
// children meanwhile and stalls only on the next node's last word, after which the
// queue fills and full rises.
// The depth cap is written with depth_cap_we; write it only while the block is idle.
// Reset clears the queue, the node tracking and the result valid flag, and sets
// the depth cap to 32. The block accepts words as soon as reset is released.
module proof_number_node_evaluator #(
	parameter int unsigned MAX_CHILDREN = pne_pkg::MAX_CHILDREN_DEF,
	parameter int unsigned SUBTREE_BITS = pne_pkg::SUBTREE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  pne_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output pne_pkg::result_t result,
	input  logic             depth_cap_we,
	input  logic [15:0]      depth_cap_wdata
);

	logic [15:0]     depth_cap_q;
	logic            q_push;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;
	pne_pkg::work_t  q_in;
	pne_pkg::work_t  q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cap_q <= pne_pkg::DEPTH_CAP_RESET;
		end else if (depth_cap_we) begin
			depth_cap_q <= depth_cap_wdata;
		end
	end

	assign full = q_full;

	pne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.item      (item),
		.depth_cap (depth_cap_q),
		.q_push    (q_push),
		.q_word    (q_in)
	);

	pne_queue #(
		.WIDTH ($bits(pne_pkg::work_t)),
		.DEPTH (pne_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_out),
		.valid   (q_valid)
	);

	pne_back #(
		.MAX_CHILDREN (MAX_CHILDREN),
		.SUBTREE_BITS (SUBTREE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_word  (q_out),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[hw/rtl/pne_checker.sv]
// Port-level checks for the proof-number node evaluator, bound to the top level.
module pne_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input pne_pkg::result_t result
);

	// Reset must leave no stale result visible.
	assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result visible during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished before pop");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.explore_found) |-> (result.explore_index == 10'd0))
		else $error("explore index nonzero without a selected child");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.mate_found) |-> (result.mate_index == 10'd0))
		else $error("mate index nonzero without a proven child");

endmodule

bind proof_number_node_evaluator pne_checker u_pne_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
